// ===== sv/gbs_pkg.sv =====
// shared types and constants of the grid bilinear sampler
package gbs_pkg;

  localparam int COORD_W     = 25;    // lat/lon, 16 fraction bits
  localparam int SPAN_W      = 26;    // difference of two coordinates
  localparam int VAL_W       = 32;    // grid value, q16.16
  localparam int PROD_W      = 58;    // span times value
  localparam int NUM_W       = 59;    // sum of two products
  localparam int IDX_W       = 16;    // row-major cell index
  localparam int STORE_DEPTH = 65536;
  localparam int CNT_REG_W   = 9;     // row / column count register
  localparam int STEP_W      = 24;    // step register
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 25;
  localparam int QUO_W       = 32;    // rounded quotient width before sign
  localparam int QUO_STEP    = 4;     // quotient bits per divider stage
  localparam int QUERY_SLOTS = 4;     // memory cycles taken by one query

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS       = 3'd0,
    REG_COLS       = 3'd1,
    REG_LAT_ORIGIN = 3'd2,
    REG_LON_ORIGIN = 3'd3,
    REG_LAT_STEP   = 3'd4,
    REG_LON_STEP   = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } act_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
    logic signed [VAL_W-1:0]   value;
  } grid_entry_t;

  // sideband that rides along a divider: corner index and result flag
  typedef struct packed {
    logic [IDX_W-1:0] ia;
    logic             ok;
  } idx_side_t;

  // sideband for the second pass: latitude weights and span
  typedef struct packed {
    logic signed [SPAN_W-1:0] lat_p;
    logic signed [SPAN_W-1:0] lat_m;
    logic signed [SPAN_W-1:0] dlat;
  } lat_side_t;

  function automatic logic signed [SPAN_W-1:0] sx_span(input logic signed [COORD_W-1:0] c);
    sx_span = {c[COORD_W-1], c};
  endfunction

endpackage

// ===== sv/gbs_ram.sv =====
// generic single-port ram with registered read
module gbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/gbs_rdiv.sv =====
// pipelined signed divider, round half away from zero, saturated to 32 bits
module gbs_rdiv #(
  parameter int NUM_W  = 59,
  parameter int DEN_W  = 26,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic signed [NUM_W-1:0]         in_num,
  input  logic signed [DEN_W-1:0]         in_den,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic signed [gbs_pkg::QUO_W-1:0] out_quo,
  output logic [SIDE_W-1:0]               out_side
);

  localparam int QW    = gbs_pkg::QUO_W;
  localparam int QS    = gbs_pkg::QUO_STEP;
  localparam int STEPS = QW / QS;
  localparam int NU_W  = NUM_W + 1;
  localparam int D_W   = DEN_W + 1;
  localparam int HI_W  = NU_W - QW;
  localparam int CW    = HI_W + D_W;

  // magnitudes
  logic              a_v_r, a_neg_r;
  logic [NUM_W-1:0]  a_an_r;
  logic [DEN_W-1:0]  a_ad_r;
  logic [SIDE_W-1:0] a_side_r;
  // doubled numerator plus denominator, doubled denominator
  logic              b_v_r, b_neg_r;
  logic [NU_W-1:0]   b_n_r;
  logic [D_W-1:0]    b_d_r;
  logic [SIDE_W-1:0] b_side_r;
  // restoring stages
  logic              v_r    [0:STEPS];
  logic              neg_r  [0:STEPS];
  logic              ovf_r  [0:STEPS];
  logic [D_W-1:0]    d_r    [0:STEPS];
  logic [D_W-1:0]    rem_r  [0:STEPS];
  logic [QW-1:0]     low_r  [0:STEPS];
  logic [QW-1:0]     q_r    [0:STEPS];
  logic [SIDE_W-1:0] side_r [0:STEPS];
  // result
  logic              out_valid_r;
  logic [QW-1:0]     out_quo_r;
  logic [SIDE_W-1:0] out_side_r;

  logic [HI_W-1:0]   hi;
  logic [QW-1:0]     quo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      v_r[0] <= b_v_r;
    end
    a_neg_r  <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
    a_an_r   <= in_num[NUM_W-1] ? NUM_W'(~in_num + 1'b1) : NUM_W'(in_num);
    a_ad_r   <= in_den[DEN_W-1] ? DEN_W'(~in_den + 1'b1) : DEN_W'(in_den);
    a_side_r <= in_side;
    b_neg_r  <= a_neg_r;
    b_n_r    <= {a_an_r, 1'b0} + NU_W'(a_ad_r);
    b_d_r    <= {a_ad_r, 1'b0};
    b_side_r <= a_side_r;
    neg_r[0]  <= b_neg_r;
    ovf_r[0]  <= CW'(hi) >= CW'(b_d_r);
    d_r[0]    <= b_d_r;
    rem_r[0]  <= hi[D_W-1:0];
    low_r[0]  <= b_n_r[QW-1:0];
    q_r[0]    <= '0;
    side_r[0] <= b_side_r;
  end

  assign hi = b_n_r[NU_W-1:QW];

  for (genvar k = 1; k <= STEPS; k++) begin : g_stp
    logic [D_W:0]   t;
    logic [D_W-1:0] rem_c;
    logic [QW-1:0]  q_c;

    always_comb begin
      rem_c = rem_r[k-1];
      q_c   = q_r[k-1];
      t     = '0;
      for (int i = 0; i < QS; i++) begin
        t = {rem_c, low_r[k-1][QW-1-(k-1)*QS-i]};
        if (t >= {1'b0, d_r[k-1]}) begin
          t = t - {1'b0, d_r[k-1]};
          q_c[QW-1-(k-1)*QS-i] = 1'b1;
        end
        rem_c = t[D_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
      neg_r[k]  <= neg_r[k-1];
      ovf_r[k]  <= ovf_r[k-1];
      d_r[k]    <= d_r[k-1];
      rem_r[k]  <= rem_c;
      low_r[k]  <= low_r[k-1];
      q_r[k]    <= q_c;
      side_r[k] <= side_r[k-1];
    end
  end

  // sign and saturation
  always_comb begin
    if (neg_r[STEPS]) begin
      if (ovf_r[STEPS] || (q_r[STEPS] > {1'b1, {(QW-1){1'b0}}})) begin
        quo_nxt = {1'b1, {(QW-1){1'b0}}};
      end else begin
        quo_nxt = QW'(~q_r[STEPS] + 1'b1);
      end
    end else begin
      if (ovf_r[STEPS] || q_r[STEPS][QW-1]) begin
        quo_nxt = {1'b0, {(QW-1){1'b1}}};
      end else begin
        quo_nxt = q_r[STEPS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[STEPS];
    end
    out_quo_r  <= quo_nxt;
    out_side_r <= side_r[STEPS];
  end

  assign out_valid = out_valid_r;
  assign out_quo   = $signed(out_quo_r);
  assign out_side  = out_side_r;

endmodule

// ===== sv/grid_bilinear_sampler.sv =====
// top level of the grid bilinear sampler: grid store, cell search and interpolation
// A load (in_action 0) writes one grid cell and is taken every cycle while busy is
// low. A query (in_action 1) raises busy after its transfer to space queries out:
// the four corner cells of each come out of one single-port grid ram, one per cycle.
// Loads and queries may be mixed freely and keep their order. A query returns one
// result on out_valid; the pipeline never stalls, so results must be taken in the
// cycle they are shown. Loads return nothing. The grid ram holds 65536 cells and
// is not cleared; reading a cell never loaded gives an unspecified value.
module grid_bilinear_sampler #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_action,
  input  logic [gbs_pkg::IDX_W-1:0]              in_cell_index,
  input  logic signed [gbs_pkg::COORD_W-1:0]     in_cell_lat,
  input  logic signed [gbs_pkg::COORD_W-1:0]     in_cell_lon,
  input  logic signed [gbs_pkg::VAL_W-1:0]       in_cell_value,
  input  logic signed [gbs_pkg::COORD_W-1:0]     in_point_lat,
  input  logic signed [gbs_pkg::COORD_W-1:0]     in_point_lon,
  input  logic                                   cfg_we,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  output logic                                   out_valid,
  output logic                                   out_in_bounds,
  output logic signed [gbs_pkg::VAL_W-1:0]       out_sample_value,
  output logic [gbs_pkg::IDX_W-1:0]              out_corner_index
);

  localparam int CW    = gbs_pkg::COORD_W;
  localparam int SW    = gbs_pkg::SPAN_W;
  localparam int VW    = gbs_pkg::VAL_W;
  localparam int PW    = gbs_pkg::PROD_W;
  localparam int NW    = gbs_pkg::NUM_W;
  localparam int IW    = gbs_pkg::IDX_W;
  localparam int STW   = gbs_pkg::STEP_W;
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int QI    = (RB > CB) ? RB : CB;   // bits of a row or column number
  localparam int CNT_W = QI + 1;
  localparam int EXT_W = (CNT_W > gbs_pkg::CNT_REG_W) ? CNT_W : gbs_pkg::CNT_REG_W;
  localparam int MUL_W = CNT_W + QI + IW;
  localparam int LD    = QI + 2;                // load delay to the ram port
  localparam int ISW   = $bits(gbs_pkg::idx_side_t);
  localparam int LSW   = $bits(gbs_pkg::lat_side_t);
  localparam int EW    = $bits(gbs_pkg::grid_entry_t);

  // ---------------------------------------------------------------- config
  logic [gbs_pkg::CNT_REG_W-1:0] grid_rows_r, grid_cols_r;
  logic signed [CW-1:0]          lat_origin_r, lon_origin_r;
  logic [STW-1:0]                lat_step_r, lon_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r  <= 9'd256;
      grid_cols_r  <= 9'd256;
      lat_origin_r <= '0;
      lon_origin_r <= '0;
      lat_step_r   <= 24'd65536;
      lon_step_r   <= 24'd65536;
    end else if (cfg_we) begin
      unique case (gbs_pkg::cfg_idx_t'(cfg_index))
        gbs_pkg::REG_ROWS:       grid_rows_r  <= cfg_wdata[gbs_pkg::CNT_REG_W-1:0];
        gbs_pkg::REG_COLS:       grid_cols_r  <= cfg_wdata[gbs_pkg::CNT_REG_W-1:0];
        gbs_pkg::REG_LAT_ORIGIN: lat_origin_r <= $signed(cfg_wdata[CW-1:0]);
        gbs_pkg::REG_LON_ORIGIN: lon_origin_r <= $signed(cfg_wdata[CW-1:0]);
        gbs_pkg::REG_LAT_STEP:   lat_step_r   <= cfg_wdata[STW-1:0];
        gbs_pkg::REG_LON_STEP:   lon_step_r   <= cfg_wdata[STW-1:0];
        default: ;
      endcase
    end
  end

  // effective counts, clamped to the build limits
  logic [CNT_W-1:0] rows_eff, cols_eff;
  assign rows_eff = (EXT_W'(grid_rows_r) > EXT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS)
                                                             : CNT_W'(grid_rows_r);
  assign cols_eff = (EXT_W'(grid_cols_r) > EXT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS)
                                                             : CNT_W'(grid_cols_r);

  // ---------------------------------------------------------------- input
  logic       acc, q_acc, l_acc;
  logic [1:0] busy_cnt_r;

  assign busy  = (busy_cnt_r != 2'd0);
  assign acc   = start && !busy;
  assign q_acc = acc && (in_action == gbs_pkg::ACT_QUERY);
  assign l_acc = acc && (in_action == gbs_pkg::ACT_LOAD);

  // a query owns the ram port for its four corner reads, so hold off the next transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_cnt_r <= 2'd0;
    end else if (q_acc) begin
      busy_cnt_r <= 2'(gbs_pkg::QUERY_SLOTS - 1);
    end else if (busy_cnt_r != 2'd0) begin
      busy_cnt_r <= busy_cnt_r - 2'd1;
    end
  end

  // loads travel a delay line so they hit the ram in transfer order
  logic                  ld_v_r    [0:LD-1];
  logic [IW-1:0]         ld_idx_r  [0:LD-1];
  gbs_pkg::grid_entry_t  ld_data_r [0:LD-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LD; i++) begin
        ld_v_r[i] <= 1'b0;
      end
    end else begin
      ld_v_r[0] <= l_acc;
      for (int i = 1; i < LD; i++) begin
        ld_v_r[i] <= ld_v_r[i-1];
      end
    end
    ld_idx_r[0]        <= in_cell_index;
    ld_data_r[0].lat   <= in_cell_lat;
    ld_data_r[0].lon   <= in_cell_lon;
    ld_data_r[0].value <= in_cell_value;
    for (int i = 1; i < LD; i++) begin
      ld_idx_r[i]  <= ld_idx_r[i-1];
      ld_data_r[i] <= ld_data_r[i-1];
    end
  end

  // ---------------------------------------------------------------- cell search
  // floor((point - origin) / step), one quotient bit per stage; a negative
  // offset, a quotient past QI bits or a zero step is already off grid
  logic signed [SW-1:0] diff_lat, diff_lon;
  logic                 ovf_lat, ovf_lon, bad0;

  assign diff_lat = gbs_pkg::sx_span(in_point_lat) - gbs_pkg::sx_span(lat_origin_r);
  assign diff_lon = gbs_pkg::sx_span(in_point_lon) - gbs_pkg::sx_span(lon_origin_r);
  assign ovf_lat  = CW'(diff_lat[CW-1:QI]) >= CW'(lat_step_r);
  assign ovf_lon  = CW'(diff_lon[CW-1:QI]) >= CW'(lon_step_r);
  assign bad0     = diff_lat[SW-1] || diff_lon[SW-1] || ovf_lat || ovf_lon ||
                    (lat_step_r == '0) || (lon_step_r == '0);

  logic                 fl_v_r       [0:QI];
  logic                 fl_bad_r     [0:QI];
  logic [STW-1:0]       fl_lat_rem_r [0:QI];
  logic [STW-1:0]       fl_lon_rem_r [0:QI];
  logic [QI-1:0]        fl_lat_low_r [0:QI];
  logic [QI-1:0]        fl_lon_low_r [0:QI];
  logic [QI-1:0]        fl_lat_q_r   [0:QI];
  logic [QI-1:0]        fl_lon_q_r   [0:QI];
  logic signed [CW-1:0] fl_plat_r    [0:QI];
  logic signed [CW-1:0] fl_plon_r    [0:QI];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fl_v_r[0] <= 1'b0;
    end else begin
      fl_v_r[0] <= q_acc;
    end
    fl_bad_r[0]     <= bad0;
    fl_lat_rem_r[0] <= STW'(diff_lat[CW-1:QI]);
    fl_lon_rem_r[0] <= STW'(diff_lon[CW-1:QI]);
    fl_lat_low_r[0] <= diff_lat[QI-1:0];
    fl_lon_low_r[0] <= diff_lon[QI-1:0];
    fl_lat_q_r[0]   <= '0;
    fl_lon_q_r[0]   <= '0;
    fl_plat_r[0]    <= in_point_lat;
    fl_plon_r[0]    <= in_point_lon;
  end

  for (genvar k = 1; k <= QI; k++) begin : g_fl
    logic [STW:0]   t_lat, t_lon;
    logic [STW-1:0] rem_lat, rem_lon;
    logic [QI-1:0]  q_lat, q_lon;

    always_comb begin
      t_lat   = {fl_lat_rem_r[k-1], fl_lat_low_r[k-1][QI-k]};
      t_lon   = {fl_lon_rem_r[k-1], fl_lon_low_r[k-1][QI-k]};
      rem_lat = t_lat[STW-1:0];
      rem_lon = t_lon[STW-1:0];
      q_lat   = fl_lat_q_r[k-1];
      q_lon   = fl_lon_q_r[k-1];
      if (t_lat >= {1'b0, lat_step_r}) begin
        rem_lat      = STW'(t_lat - {1'b0, lat_step_r});
        q_lat[QI-k]  = 1'b1;
      end
      if (t_lon >= {1'b0, lon_step_r}) begin
        rem_lon      = STW'(t_lon - {1'b0, lon_step_r});
        q_lon[QI-k]  = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fl_v_r[k] <= 1'b0;
      end else begin
        fl_v_r[k] <= fl_v_r[k-1];
      end
      fl_bad_r[k]     <= fl_bad_r[k-1];
      fl_lat_rem_r[k] <= rem_lat;
      fl_lon_rem_r[k] <= rem_lon;
      fl_lat_low_r[k] <= fl_lat_low_r[k-1];
      fl_lon_low_r[k] <= fl_lon_low_r[k-1];
      fl_lat_q_r[k]   <= q_lat;
      fl_lon_q_r[k]   <= q_lon;
      fl_plat_r[k]    <= fl_plat_r[k-1];
      fl_plon_r[k]    <= fl_plon_r[k-1];
    end
  end

  // bounds check and lower corner index
  logic             oob;
  logic [MUL_W-1:0] ia_full;

  assign oob = fl_bad_r[QI] ||
               ((CNT_W'(fl_lat_q_r[QI]) + 1'b1) >= rows_eff) ||
               ((CNT_W'(fl_lon_q_r[QI]) + 1'b1) >= cols_eff);
  assign ia_full = MUL_W'(cols_eff) * MUL_W'(fl_lat_q_r[QI]) + MUL_W'(fl_lon_q_r[QI]);

  logic                 x_v_r, x_ok_r;
  logic [IW-1:0]        x_ia_r;
  logic signed [CW-1:0] x_plat_r, x_plon_r;

  // held from one query until the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r <= 1'b0;
    end else begin
      x_v_r <= fl_v_r[QI];
    end
    if (fl_v_r[QI]) begin
      x_ok_r   <= !oob;
      x_ia_r   <= oob ? '0 : ia_full[IW-1:0];
      x_plat_r <= fl_plat_r[QI];
      x_plon_r <= fl_plon_r[QI];
    end
  end

  // ---------------------------------------------------------------- corner reads
  logic [4:1]           tap_r;     // delayed copies of x_v_r, which marks the first corner read
  logic                 mem_we;
  logic [IW-1:0]        mem_addr;
  logic [EW-1:0]        mem_rdata;
  gbs_pkg::grid_entry_t rd_ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else begin
      tap_r <= {tap_r[3:1], x_v_r};
    end
  end

  assign mem_we = ld_v_r[LD-1];

  always_comb begin
    if (mem_we) begin
      mem_addr = ld_idx_r[LD-1];
    end else if (tap_r[1]) begin
      mem_addr = x_ia_r + IW'(1);
    end else if (tap_r[2]) begin
      mem_addr = x_ia_r + IW'(cols_eff);
    end else if (tap_r[3]) begin
      mem_addr = x_ia_r + IW'(cols_eff) + IW'(1);
    end else begin
      mem_addr = x_ia_r;
    end
  end

  gbs_ram #(
    .WIDTH (EW),
    .DEPTH (gbs_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (ld_data_r[LD-1]),
    .rdata (mem_rdata)
  );

  assign rd_ent = gbs_pkg::grid_entry_t'(mem_rdata);

  // corner gather: a arrives after tap 1, b after tap 2, c after tap 3, d at tap 4
  logic signed [CW-1:0] g_lat_a_r, g_lon_a_r, g_lon_b_r, g_lat_c_r;
  logic signed [VW-1:0] g_val_a_r, g_val_b_r, g_val_c_r;
  logic signed [CW-1:0] g_plat_r, g_plon_r;
  logic [IW-1:0]        g_ia_r;
  logic                 g_ok_r;

  always_ff @(posedge clk) begin
    if (tap_r[1]) begin
      g_lat_a_r <= rd_ent.lat;
      g_lon_a_r <= rd_ent.lon;
      g_val_a_r <= rd_ent.value;
      g_plat_r  <= x_plat_r;
      g_plon_r  <= x_plon_r;
      g_ia_r    <= x_ia_r;
      g_ok_r    <= x_ok_r;
    end
    if (tap_r[2]) begin
      g_lon_b_r <= rd_ent.lon;
      g_val_b_r <= rd_ent.value;
    end
    if (tap_r[3]) begin
      g_lat_c_r <= rd_ent.lat;
      g_val_c_r <= rd_ent.value;
    end
  end

  // ---------------------------------------------------------------- first pass
  logic                 m1_v_r, m1_ok_r;
  logic [IW-1:0]        m1_ia_r;
  logic signed [SW-1:0] m1_dlon_r, m1_dlat_r, m1_lon_m_r, m1_lon_p_r, m1_lat_m_r, m1_lat_p_r;
  logic signed [VW-1:0] m1_val_a_r, m1_val_b_r, m1_val_c_r, m1_val_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else begin
      m1_v_r <= tap_r[4];
    end
    m1_ok_r    <= g_ok_r;
    m1_ia_r    <= g_ia_r;
    m1_dlon_r  <= gbs_pkg::sx_span(g_lon_b_r) - gbs_pkg::sx_span(g_lon_a_r);
    m1_dlat_r  <= gbs_pkg::sx_span(g_lat_c_r) - gbs_pkg::sx_span(g_lat_a_r);
    m1_lon_m_r <= gbs_pkg::sx_span(g_plon_r) - gbs_pkg::sx_span(g_lon_a_r);
    m1_lon_p_r <= gbs_pkg::sx_span(g_lon_b_r) - gbs_pkg::sx_span(g_plon_r);
    m1_lat_m_r <= gbs_pkg::sx_span(g_plat_r) - gbs_pkg::sx_span(g_lat_a_r);
    m1_lat_p_r <= gbs_pkg::sx_span(g_lat_c_r) - gbs_pkg::sx_span(g_plat_r);
    m1_val_a_r <= g_val_a_r;
    m1_val_b_r <= g_val_b_r;
    m1_val_c_r <= g_val_c_r;
    m1_val_d_r <= rd_ent.value;
  end

  // weight products; zero span drops the in-bounds flag but keeps the corner
  logic                 m2_v_r, m2_ok_r;
  logic [IW-1:0]        m2_ia_r;
  logic signed [SW-1:0] m2_dlon_r, m2_dlat_r, m2_lat_m_r, m2_lat_p_r;
  logic signed [PW-1:0] m2_p1_r, m2_p2_r, m2_p3_r, m2_p4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else begin
      m2_v_r <= m1_v_r;
    end
    m2_ok_r    <= m1_ok_r && (m1_dlon_r != '0) && (m1_dlat_r != '0);
    m2_ia_r    <= m1_ia_r;
    m2_dlon_r  <= m1_dlon_r;
    m2_dlat_r  <= m1_dlat_r;
    m2_lat_m_r <= m1_lat_m_r;
    m2_lat_p_r <= m1_lat_p_r;
    m2_p1_r    <= m1_lon_p_r * m1_val_a_r;
    m2_p2_r    <= m1_lon_m_r * m1_val_b_r;
    m2_p3_r    <= m1_lon_p_r * m1_val_c_r;
    m2_p4_r    <= m1_lon_m_r * m1_val_d_r;
  end

  logic                 m3_v_r;
  logic signed [NW-1:0] m3_n1_r, m3_n2_r;
  logic signed [SW-1:0] m3_dlon_r;
  gbs_pkg::idx_side_t   m3_is_r;
  gbs_pkg::lat_side_t   m3_ls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else begin
      m3_v_r <= m2_v_r;
    end
    m3_n1_r       <= NW'(m2_p1_r) + NW'(m2_p2_r);
    m3_n2_r       <= NW'(m2_p3_r) + NW'(m2_p4_r);
    m3_dlon_r     <= m2_dlon_r;
    m3_is_r.ia    <= m2_ia_r;
    m3_is_r.ok    <= m2_ok_r;
    m3_ls_r.lat_p <= m2_lat_p_r;
    m3_ls_r.lat_m <= m2_lat_m_r;
    m3_ls_r.dlat  <= m2_dlat_r;
  end

  // r1 and r2 share the longitude span and run side by side
  logic                 r1_v, r2_v;
  logic signed [VW-1:0] r1_quo, r2_quo;
  logic [ISW-1:0]       r1_side;
  logic [LSW-1:0]       r2_side;

  gbs_rdiv #(.NUM_W(NW), .DEN_W(SW), .SIDE_W(ISW)) u_div_r1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m3_v_r),
    .in_num    (m3_n1_r),
    .in_den    (m3_dlon_r),
    .in_side   (m3_is_r),
    .out_valid (r1_v),
    .out_quo   (r1_quo),
    .out_side  (r1_side)
  );

  gbs_rdiv #(.NUM_W(NW), .DEN_W(SW), .SIDE_W(LSW)) u_div_r2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m3_v_r),
    .in_num    (m3_n2_r),
    .in_den    (m3_dlon_r),
    .in_side   (m3_ls_r),
    .out_valid (r2_v),
    .out_quo   (r2_quo),
    .out_side  (r2_side)
  );

  // ---------------------------------------------------------------- second pass
  gbs_pkg::lat_side_t   r2_ls;
  logic                 f1_v_r;
  logic signed [PW-1:0] f1_p1_r, f1_p2_r;
  logic signed [SW-1:0] f1_dlat_r;
  logic [ISW-1:0]       f1_is_r;

  assign r2_ls = gbs_pkg::lat_side_t'(r2_side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= r1_v && r2_v;
    end
    f1_p1_r   <= r2_ls.lat_p * r1_quo;
    f1_p2_r   <= r2_ls.lat_m * r2_quo;
    f1_dlat_r <= r2_ls.dlat;
    f1_is_r   <= r1_side;
  end

  logic                 f2_v_r;
  logic signed [NW-1:0] f2_n_r;
  logic signed [SW-1:0] f2_dlat_r;
  logic [ISW-1:0]       f2_is_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= f1_v_r;
    end
    f2_n_r    <= NW'(f1_p1_r) + NW'(f1_p2_r);
    f2_dlat_r <= f1_dlat_r;
    f2_is_r   <= f1_is_r;
  end

  logic                 f_v;
  logic signed [VW-1:0] f_quo;
  logic [ISW-1:0]       f_side;
  gbs_pkg::idx_side_t   f_is;

  gbs_rdiv #(.NUM_W(NW), .DEN_W(SW), .SIDE_W(ISW)) u_div_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f2_v_r),
    .in_num    (f2_n_r),
    .in_den    (f2_dlat_r),
    .in_side   (f2_is_r),
    .out_valid (f_v),
    .out_quo   (f_quo),
    .out_side  (f_side)
  );

  assign f_is = gbs_pkg::idx_side_t'(f_side);

  // ---------------------------------------------------------------- result
  logic                 out_valid_r, out_in_bounds_r;
  logic signed [VW-1:0] out_sample_value_r;
  logic [IW-1:0]        out_corner_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f_v;
    end
    if (f_v) begin
      out_in_bounds_r    <= f_is.ok;
      out_sample_value_r <= f_is.ok ? f_quo : '0;
      out_corner_index_r <= f_is.ia;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_in_bounds    = out_in_bounds_r;
  assign out_sample_value = out_sample_value_r;
  assign out_corner_index = out_corner_index_r;

  // ---------------------------------------------------------------- checks
  // a delayed load write never lands on a corner read cycle
  a_ram_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && (x_v_r || tap_r[1] || tap_r[2] || tap_r[3])))
    else $error("load write collides with corner read");

  // a query transfer blocks the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == gbs_pkg::ACT_QUERY)) |=> busy)
    else $error("busy not raised after query transfer");

  // results never come in back-to-back cycles
  a_out_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in back-to-back cycles");

  // both first-pass dividers finish together
  a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    r1_v == r2_v)
    else $error("first-pass dividers out of step");

endmodule

// ===== tb/grid_bilinear_sampler_check.sv =====
// checker for the grid bilinear sampler: grid copy, sample prediction and result compare
module grid_bilinear_sampler_check #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               in_action,
  input  logic [gbs_pkg::IDX_W-1:0]          in_cell_index,
  input  logic signed [gbs_pkg::COORD_W-1:0] in_cell_lat,
  input  logic signed [gbs_pkg::COORD_W-1:0] in_cell_lon,
  input  logic signed [gbs_pkg::VAL_W-1:0]   in_cell_value,
  input  logic signed [gbs_pkg::COORD_W-1:0] in_point_lat,
  input  logic signed [gbs_pkg::COORD_W-1:0] in_point_lon,
  input  logic                               cfg_we,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gbs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               out_valid,
  input  logic                               out_in_bounds,
  input  logic signed [gbs_pkg::VAL_W-1:0]   out_sample_value,
  input  logic [gbs_pkg::IDX_W-1:0]          out_corner_index,
  output int                                 fails,
  output int                                 pending
);

  typedef struct {
    logic                             in_bounds;
    logic signed [gbs_pkg::VAL_W-1:0] value;
    logic [gbs_pkg::IDX_W-1:0]        corner;
  } sample_t;

  // grid copy, only ever read at cells that were loaded
  int lat_mem[int];
  int lon_mem[int];
  int val_mem[int];

  logic [gbs_pkg::CNT_REG_W-1:0]      rows_reg, cols_reg;
  logic signed [gbs_pkg::COORD_W-1:0] lat_origin, lon_origin;
  logic [gbs_pkg::STEP_W-1:0]         lat_step, lon_step;

  sample_t samples_due[$];

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // nearest, ties away from zero, then clamp to 32 bits
  function automatic longint round_sat(longint n, longint d);
    bit                neg;
    longint unsigned   an, ad, q;
    neg = (n < 0) != (d < 0);
    an = (n < 0) ? longint'(-n) : n;
    ad = (d < 0) ? longint'(-d) : d;
    q = (2 * an + ad) / (2 * ad);
    if (neg) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic sample_t predict_sample(longint plat, longint plon);
    sample_t s;
    longint  rows, cols, lo_r, lo_c, dlon, dlat, lon_m, lon_p, lat_m, lat_p, r1, r2, f;
    int      ia, ib, ic, id;
    s.in_bounds = 1'b0;
    s.value = '0;
    s.corner = '0;
    if (lat_step == 0 || lon_step == 0) return s;
    rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    lo_r = floor_quot(plat - longint'(lat_origin), longint'(lat_step));
    lo_c = floor_quot(plon - longint'(lon_origin), longint'(lon_step));
    if (lo_r < 0 || lo_r + 1 >= rows || lo_c < 0 || lo_c + 1 >= cols) return s;
    ia = int'((cols * lo_r + lo_c) & 64'hFFFF);
    ib = int'((cols * lo_r + lo_c + 1) & 64'hFFFF);
    ic = int'((cols * (lo_r + 1) + lo_c) & 64'hFFFF);
    id = int'((cols * (lo_r + 1) + lo_c + 1) & 64'hFFFF);
    s.corner = ia[gbs_pkg::IDX_W-1:0];
    dlon = longint'(lon_mem[ib]) - longint'(lon_mem[ia]);
    dlat = longint'(lat_mem[ic]) - longint'(lat_mem[ia]);
    if (dlon == 0 || dlat == 0) return s;
    lon_m = plon - longint'(lon_mem[ia]);
    lon_p = longint'(lon_mem[ib]) - plon;
    lat_m = plat - longint'(lat_mem[ia]);
    lat_p = longint'(lat_mem[ic]) - plat;
    r1 = round_sat(lon_p * longint'(val_mem[ia]) + lon_m * longint'(val_mem[ib]), dlon);
    r2 = round_sat(lon_p * longint'(val_mem[ic]) + lon_m * longint'(val_mem[id]), dlon);
    f = round_sat(lat_p * r1 + lat_m * r2, dlat);
    s.in_bounds = 1'b1;
    s.value = f[gbs_pkg::VAL_W-1:0];
    return s;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      rows_reg <= 9'd256;
      cols_reg <= 9'd256;
      lat_origin <= '0;
      lon_origin <= '0;
      lat_step <= 24'd65536;
      lon_step <= 24'd65536;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gbs_pkg::REG_ROWS:       rows_reg <= cfg_wdata[gbs_pkg::CNT_REG_W-1:0];
          gbs_pkg::REG_COLS:       cols_reg <= cfg_wdata[gbs_pkg::CNT_REG_W-1:0];
          gbs_pkg::REG_LAT_ORIGIN: lat_origin <= cfg_wdata[gbs_pkg::COORD_W-1:0];
          gbs_pkg::REG_LON_ORIGIN: lon_origin <= cfg_wdata[gbs_pkg::COORD_W-1:0];
          gbs_pkg::REG_LAT_STEP:   lat_step <= cfg_wdata[gbs_pkg::STEP_W-1:0];
          gbs_pkg::REG_LON_STEP:   lon_step <= cfg_wdata[gbs_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      // result first, so a query taken at the same edge is never matched
      if (out_valid) begin
        if (samples_due.size() == 0) begin
          $display("%0t: result with nothing expected: in_bounds %0b value %0d corner %0d",
                   $time, out_in_bounds, out_sample_value, out_corner_index);
          fails = fails + 1;
        end else begin
          want = samples_due.pop_front();
          if (out_in_bounds !== want.in_bounds) begin
            $display("%0t: in_bounds expected %0b actual %0b",
                     $time, want.in_bounds, out_in_bounds);
            fails = fails + 1;
          end
          if (out_sample_value !== want.value) begin
            $display("%0t: sample_value expected %0d actual %0d",
                     $time, want.value, out_sample_value);
            fails = fails + 1;
          end
          if (out_corner_index !== want.corner) begin
            $display("%0t: corner_index expected %0d actual %0d",
                     $time, want.corner, out_corner_index);
            fails = fails + 1;
          end
        end
      end
      if (start && !busy) begin
        if (gbs_pkg::act_t'(in_action) == gbs_pkg::ACT_LOAD) begin
          lat_mem[int'(in_cell_index)] = int'(in_cell_lat);
          lon_mem[int'(in_cell_index)] = int'(in_cell_lon);
          val_mem[int'(in_cell_index)] = int'(in_cell_value);
        end else begin
          samples_due.push_back(predict_sample(longint'(in_point_lat),
                                               longint'(in_point_lon)));
        end
      end
      pending = samples_due.size();
    end
  end

endmodule

// ===== tb/grid_bilinear_sampler_test.sv =====
// stimulus and verdict for the grid bilinear sampler
module grid_bilinear_sampler_test;

  localparam int     MAX_DIM    = 256;
  localparam longint COORD_MAX  = 11796480;
  localparam int     DRAIN      = 60;      // longer than the query latency
  localparam int     LIMIT      = 600000;  // cycles before the run is called hung
  localparam int     PHASES     = 14;
  localparam int     PHASE_ITEMS = 20;

  logic                               clk;
  logic                               rst_n;
  logic                               start;
  logic                               busy;
  logic                               in_action;
  logic [gbs_pkg::IDX_W-1:0]          in_cell_index;
  logic signed [gbs_pkg::COORD_W-1:0] in_cell_lat;
  logic signed [gbs_pkg::COORD_W-1:0] in_cell_lon;
  logic signed [gbs_pkg::VAL_W-1:0]   in_cell_value;
  logic signed [gbs_pkg::COORD_W-1:0] in_point_lat;
  logic signed [gbs_pkg::COORD_W-1:0] in_point_lon;
  logic                               cfg_we;
  logic [gbs_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [gbs_pkg::CFG_DATA_W-1:0]     cfg_wdata;
  logic                               out_valid;
  logic                               out_in_bounds;
  logic signed [gbs_pkg::VAL_W-1:0]   out_sample_value;
  logic [gbs_pkg::IDX_W-1:0]          out_corner_index;
  int                                 fails;
  int                                 pending;
  int                                 cycles = 0;
  int                                 idle_pct;

  // our own view of the settings, used to aim points at loaded cells
  int     rows_set, cols_set;
  longint lat_org, lon_org, lat_stp, lon_stp;
  bit     written[gbs_pkg::STORE_DEPTH];
  int     blk_r0, blk_c0, blk_nr, blk_nc;
  bit     have_block;

  grid_bilinear_sampler DUT (.*);

  grid_bilinear_sampler_check checker_i (.*);

  // free-running clock, period 12
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("grid_bilinear_sampler: mismatch");
      $finish;
    end
  end

  function automatic int eff_dim(int n);
    return (n > MAX_DIM) ? MAX_DIM : n;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < -COORD_MAX) return -COORD_MAX;
    return v;
  endfunction

  function automatic int cell_at(longint r, longint c);
    return int'((eff_dim(cols_set) * r + c) & 64'hFFFF);
  endfunction

  // true unless the query would read a corner that was never loaded
  function automatic bit query_safe(longint plat, longint plon);
    longint lo_r, lo_c;
    if (lat_stp == 0 || lon_stp == 0) return 1'b1;
    lo_r = floor_quot(plat - lat_org, lat_stp);
    lo_c = floor_quot(plon - lon_org, lon_stp);
    if (lo_r < 0 || lo_r + 1 >= eff_dim(rows_set) || lo_c < 0 || lo_c + 1 >= eff_dim(cols_set))
      return 1'b1;
    return written[cell_at(lo_r, lo_c)] && written[cell_at(lo_r, lo_c + 1)] &&
           written[cell_at(lo_r + 1, lo_c)] && written[cell_at(lo_r + 1, lo_c + 1)];
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send(gbs_pkg::act_t act, int idx, longint clat, longint clon, longint cval,
                      longint plat, longint plon);
    logic b;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_cell_index <= idx[gbs_pkg::IDX_W-1:0];
    in_cell_lat <= clat[gbs_pkg::COORD_W-1:0];
    in_cell_lon <= clon[gbs_pkg::COORD_W-1:0];
    in_cell_value <= cval[gbs_pkg::VAL_W-1:0];
    in_point_lat <= plat[gbs_pkg::COORD_W-1:0];
    in_point_lon <= plon[gbs_pkg::COORD_W-1:0];
    if (act == gbs_pkg::ACT_LOAD) written[idx] = 1'b1;
    // busy is registered, so sample it mid-cycle
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
  endtask

  function automatic longint rand_value();
    case ($urandom_range(7))
      0:       return 64'sd2147483647;
      1:       return -64'sd2147483648;
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  // flat 1 gives the block one latitude, flat 2 one longitude: zero span
  task automatic load_cell(int r, int c, int flat);
    longint clat, clon;
    clat = (flat == 1) ? lat_org + blk_r0 * lat_stp
                       : lat_org + r * lat_stp + $signed($urandom_range(0, lat_stp / 4))
                         * ($urandom_range(1) ? 1 : -1);
    clon = (flat == 2) ? lon_org + blk_c0 * lon_stp
                       : lon_org + c * lon_stp + $signed($urandom_range(0, lon_stp / 4))
                         * ($urandom_range(1) ? 1 : -1);
    send(gbs_pkg::ACT_LOAD, cell_at(r, c), clamp_coord(clat), clamp_coord(clon), rand_value(),
         longint'($signed($urandom_range(0, 2 * COORD_MAX))) - COORD_MAX, 0);
  endtask

  task automatic load_block(int r0, int c0, int nr, int nc, int flat);
    blk_r0 = r0;
    blk_c0 = c0;
    blk_nr = nr;
    blk_nc = nc;
    have_block = 1'b1;
    for (int r = r0; r < r0 + nr; r++)
      for (int c = c0; c < c0 + nc; c++)
        load_cell(r, c, flat);
  endtask

  // point inside one loaded block cell, otherwise random across the field range
  task automatic query_point(bit in_block);
    longint plat, plon;
    int     r, c;
    plat = longint'($signed($urandom_range(0, 2 * COORD_MAX))) - COORD_MAX;
    plon = longint'($signed($urandom_range(0, 2 * COORD_MAX))) - COORD_MAX;
    if ((in_block || !query_safe(plat, plon)) && have_block) begin
      r = blk_r0 + $urandom_range(0, blk_nr - 2);
      c = blk_c0 + $urandom_range(0, blk_nc - 2);
      plat = lat_org + r * lat_stp + ((lat_stp > 0) ? $urandom_range(0, lat_stp - 1) : 0);
      plon = lon_org + c * lon_stp + ((lon_stp > 0) ? $urandom_range(0, lon_stp - 1) : 0);
    end
    if (query_safe(plat, plon))
      send(gbs_pkg::ACT_QUERY, $urandom_range(0, 65535), 0, 0, 0, plat, plon);
  endtask

  // stop sending, let queries drain, then let the pipe settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic cfg_write(gbs_pkg::cfg_idx_t idx, longint data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[gbs_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_grid(int rows, int cols, longint lat_o, longint lon_o,
                          longint lat_s, longint lon_s);
    wait_idle();
    rows_set = rows;
    cols_set = cols;
    lat_org = lat_o;
    lon_org = lon_o;
    lat_stp = lat_s;
    lon_stp = lon_s;
    have_block = 1'b0;
    cfg_write(gbs_pkg::REG_ROWS, rows);
    cfg_write(gbs_pkg::REG_COLS, cols);
    cfg_write(gbs_pkg::REG_LAT_ORIGIN, lat_o);
    cfg_write(gbs_pkg::REG_LON_ORIGIN, lon_o);
    cfg_write(gbs_pkg::REG_LAT_STEP, lat_s);
    cfg_write(gbs_pkg::REG_LON_STEP, lon_s);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int rows, cols, nr, nc, pick;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = gbs_pkg::ACT_LOAD;
    in_cell_index = '0;
    in_cell_lat = '0;
    in_cell_lon = '0;
    in_cell_value = '0;
    in_point_lat = '0;
    in_point_lon = '0;
    cfg_we = 1'b0;
    cfg_index = gbs_pkg::REG_ROWS;
    cfg_wdata = '0;
    rows_set = 256;
    cols_set = 256;
    lat_org = 0;
    lon_org = 0;
    lat_stp = 65536;
    lon_stp = 65536;
    have_block = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, top corner of the full grid (last index 65535)
    load_block(254, 254, 2, 2, 0);
    repeat (3) query_point(1'b1);
    send(gbs_pkg::ACT_QUERY, 0, 0, 0, 0, -COORD_MAX, COORD_MAX);
    send(gbs_pkg::ACT_QUERY, 0, 0, 0, 0, COORD_MAX, -COORD_MAX);
    // point on the last row: lower corner row plus one falls off
    send(gbs_pkg::ACT_QUERY, 0, 0, 0, 0, 255 * 65536 + 100, 10 * 65536);
    // zero latitude span, then zero longitude span, at the grid origin
    load_block(0, 0, 2, 2, 1);
    query_point(1'b1);
    load_block(0, 0, 2, 2, 2);
    query_point(1'b1);
    // zero step
    set_grid(2, 2, 0, 0, 0, 65536);
    query_point(1'b0);
    set_grid(2, 2, 0, 0, 65536, 0);
    query_point(1'b0);

    // phases: extreme settings first, then random ones; idling rotates
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_grid(2, 2, -COORD_MAX, -COORD_MAX, COORD_MAX, COORD_MAX);
        1:       set_grid(511, 511, 0, 0, 1, 1);
        2:       set_grid(1, 300, 0, 0, 65536, 65536);
        3:       set_grid(0, 0, COORD_MAX, COORD_MAX, 1, 1);
        4:       set_grid(4, 4, 0, 0, 0, 0);
        default: set_grid($urandom_range(2, 20), $urandom_range(2, 20),
                          longint'($urandom_range(0, 1 << 23)) - (1 << 22),
                          longint'($urandom_range(0, 1 << 23)) - (1 << 22),
                          $urandom_range(1, 1 << 18), $urandom_range(1, 1 << 18));
      endcase
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 79;
        default: idle_pct = 10;
      endcase
      rows = eff_dim(rows_set);
      cols = eff_dim(cols_set);
      if (rows >= 2 && cols >= 2) begin
        blk_r0 = $urandom_range(0, rows - 2);
        blk_c0 = $urandom_range(0, cols - 2);
        nr = $urandom_range(2, 6);
        nc = $urandom_range(2, 6);
        if (nr > rows - blk_r0) nr = rows - blk_r0;
        if (nc > cols - blk_c0) nc = cols - blk_c0;
        pick = $urandom_range(19);
        load_block(blk_r0, blk_c0, nr, nc, (pick < 2) ? pick + 1 : 0);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          query_point(1'b1);
        end else if (pick < 82) begin
          query_point(1'b0);
        end else if (pick < 91 && have_block) begin
          // reload a block cell with fresh content
          load_cell(blk_r0 + $urandom_range(0, blk_nr - 1),
                    blk_c0 + $urandom_range(0, blk_nc - 1), 0);
        end else begin
          // stray load anywhere in the store
          send(gbs_pkg::ACT_LOAD, $urandom_range(0, 65535),
               longint'($signed($urandom_range(0, 2 * COORD_MAX))) - COORD_MAX,
               longint'($signed($urandom_range(0, 2 * COORD_MAX))) - COORD_MAX,
               rand_value(), 0, 0);
        end
      end
    end

    wait_idle();
    if (fails == 0) begin
      $display("grid_bilinear_sampler: match");
    end else begin
      $display("grid_bilinear_sampler: mismatch");
    end
    $finish;
  end

endmodule
